// ----- rtl/ppmp3_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the ppm p3 text pixel decoder
// no dependencies; compiled first

package ppmp3_pkg;

   localparam int unsigned MAX_DIM_DEFAULT = 4095;

   localparam int PIX_IDX_W  = 12;
   localparam int PIX_WORD_W = 32;
   localparam int ERR_W      = 3;
   localparam int SAMPLE_W   = 16;

   // characters the header and sample lines are checked against
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_TWO   = 8'h32;
   localparam logic [7:0] CHAR_THREE = 8'h33;
   localparam logic [7:0] CHAR_FIVE  = 8'h35;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_P     = 8'h50;

   // sticky error codes
   localparam logic [ERR_W-1:0] ERR_NONE    = 3'd0;
   localparam logic [ERR_W-1:0] ERR_MAGIC   = 3'd1;
   localparam logic [ERR_W-1:0] ERR_COMMENT = 3'd2;
   localparam logic [ERR_W-1:0] ERR_SIZE    = 3'd3;
   localparam logic [ERR_W-1:0] ERR_MAXVAL  = 3'd4;
   localparam logic [ERR_W-1:0] ERR_SAMPLE  = 3'd5;

   // color channel of the next sample line
   localparam logic [1:0] CHAN_RED   = 2'd0;
   localparam logic [1:0] CHAN_GREEN = 2'd1;
   localparam logic [1:0] CHAN_BLUE  = 2'd2;

   typedef enum logic [2:0] {
      LINE_MAGIC,
      LINE_COMMENT,
      LINE_SIZE,
      LINE_MAXVAL,
      LINE_SAMPLE
   } line_type;

   typedef struct packed {
      logic [PIX_WORD_W-1:0] pixel_word;
      logic [PIX_IDX_W-1:0]  pixel_row;
      logic [PIX_IDX_W-1:0]  pixel_column;
      logic                  last_pixel;
      logic [ERR_W-1:0]      error_code;
   } rsp_type;

endpackage

// ----- rtl/ppmp3_req_if.sv -----
`timescale 1ns / 1ps
// request channel: one text byte per request
// standalone interface, no dependencies

interface ppmp3_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

// ----- rtl/ppmp3_rsp_if.sv -----
`timescale 1ns / 1ps
// result channel: at most one decoded pixel or one error report per newline request
// standalone interface, no dependencies

interface ppmp3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_word;
   logic [11:0] pixel_row;
   logic [11:0] pixel_column;
   logic        last_pixel;
   logic [2:0]  error_code;

   modport source (output valid, output pixel_word, output pixel_row,
                   output pixel_column, output last_pixel, output error_code,
                   input ready);
   modport sink   (input valid, input pixel_word, input pixel_row,
                   input pixel_column, input last_pixel, input error_code,
                   output ready);
endinterface

// ----- rtl/ppmp3_parser.sv -----
`timescale 1ns / 1ps
// line parser: header checks, size and sample accumulation, pixel packing
// depends on ppmp3_pkg

module ppmp3_parser #(
   parameter int unsigned MAX_DIM = ppmp3_pkg::MAX_DIM_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        text_byte,
   output logic              result_valid,
   output ppmp3_pkg::rsp_type result
);
   import ppmp3_pkg::*;

   localparam int DIM_W  = $clog2(MAX_DIM + 2);
   localparam int GROW_W = DIM_W + 4;
   localparam logic [GROW_W-1:0] DIM_LIMIT = GROW_W'(MAX_DIM);
   localparam logic [DIM_W-1:0]  DIM_OVER  = DIM_W'(MAX_DIM + 1);
   localparam logic [3:0]        POS_MAX   = 4'd15;

   line_type              line_ff, line_in;
   logic [3:0]            pos_ff, pos_in;
   logic                  bad_ff, bad_in;
   logic                  space_ff, space_in;
   logic [DIM_W-1:0]      width_ff, width_in;
   logic [DIM_W-1:0]      height_ff, height_in;
   logic [SAMPLE_W-1:0]   sample_ff, sample_in;
   logic [1:0]            chan_ff, chan_in;
   logic [PIX_WORD_W-1:0] sum_ff, sum_in;
   logic [DIM_W-1:0]      row_ff, row_in;
   logic [DIM_W-1:0]      col_ff, col_in;
   logic                  done_ff, done_in;
   logic [ERR_W-1:0]      err_ff, err_in;

   logic                  active;
   logic                  newline;
   logic                  is_digit;
   logic [3:0]            digit;
   logic [DIM_W-1:0]      dim_cur;
   logic [GROW_W-1:0]     dim_wide;
   logic                  dim_over;
   logic [DIM_W-1:0]      dim_next;
   logic [19:0]           samp_wide;
   logic [SAMPLE_W-1:0]   samp_next;
   logic [PIX_WORD_W-1:0] shifted;
   logic [PIX_WORD_W-1:0] sum_next;
   logic                  pix_emit;
   logic [DIM_W:0]        row_inc;
   logic [DIM_W:0]        col_inc;
   logic                  last_pix;
   logic                  col_wrap;
   logic [ERR_W-1:0]      line_err;
   logic [31:0]           row_wide;
   logic [31:0]           col_wide;

   assign active   = step && (err_ff == ERR_NONE) && !done_ff;
   assign newline  = (text_byte == CHAR_NL);
   assign is_digit = text_byte inside {[CHAR_ZERO:CHAR_NINE]};
   assign digit    = text_byte[3:0];

   // decimal growth of width or height, clamped just past the limit
   assign dim_cur  = space_ff ? height_ff : width_ff;
   assign dim_wide = GROW_W'({dim_cur, 3'b000}) + GROW_W'({dim_cur, 1'b0})
                   + GROW_W'(digit);
   assign dim_over = (dim_wide > DIM_LIMIT);
   assign dim_next = dim_over ? DIM_OVER : dim_wide[DIM_W-1:0];

   // decimal growth of a sample, saturating
   assign samp_wide = 20'({sample_ff, 3'b000}) + 20'({sample_ff, 1'b0}) + 20'(digit);
   assign samp_next = (samp_wide > 20'h0FFFF) ? 16'hFFFF : samp_wide[SAMPLE_W-1:0];

   always_comb begin
      case (chan_ff)
         CHAN_RED:   shifted = {sample_ff, 16'h0000};
         CHAN_GREEN: shifted = {8'h00, sample_ff, 8'h00};
         default:    shifted = {16'h0000, sample_ff};
      endcase
   end

   assign sum_next = sum_ff + shifted;
   assign pix_emit = (chan_ff == CHAN_BLUE);
   assign row_inc  = {1'b0, row_ff} + 1'b1;
   assign col_inc  = {1'b0, col_ff} + 1'b1;
   assign last_pix = (row_inc == {1'b0, height_ff}) && (col_inc == {1'b0, width_ff});
   assign col_wrap = (col_inc >= {1'b0, width_ff});

   // verdict on a line when its newline arrives
   always_comb begin
      case (line_ff)
         LINE_MAGIC:   line_err = (bad_ff || pos_ff != 4'd2) ? ERR_MAGIC : ERR_NONE;
         LINE_COMMENT: line_err = (bad_ff || pos_ff == 4'd0) ? ERR_COMMENT : ERR_NONE;
         LINE_SIZE:    line_err = (bad_ff || !space_ff) ? ERR_SIZE : ERR_NONE;
         LINE_MAXVAL:  line_err = (bad_ff || pos_ff != 4'd3) ? ERR_MAXVAL : ERR_NONE;
         LINE_SAMPLE:  line_err = bad_ff ? ERR_SAMPLE : ERR_NONE;
         default:      line_err = ERR_NONE;
      endcase
   end

   // next state
   always_comb begin
      line_in   = line_ff;
      pos_in    = pos_ff;
      bad_in    = bad_ff;
      space_in  = space_ff;
      width_in  = width_ff;
      height_in = height_ff;
      sample_in = sample_ff;
      chan_in   = chan_ff;
      sum_in    = sum_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      done_in   = done_ff;
      err_in    = err_ff;
      if (active && !newline) begin
         case (line_ff)
            LINE_MAGIC: begin
               if (pos_ff >= 4'd2 ||
                   text_byte != ((pos_ff == 4'd0) ? CHAR_P : CHAR_THREE))
                  bad_in = 1'b1;
            end
            LINE_COMMENT: begin
               if (pos_ff == 4'd0 && text_byte != CHAR_HASH)
                  bad_in = 1'b1;
            end
            LINE_SIZE: begin
               if (is_digit) begin
                  if (dim_over)
                     bad_in = 1'b1;
                  if (space_ff)
                     height_in = dim_next;
                  else
                     width_in = dim_next;
               end else if (text_byte == CHAR_SPACE && pos_ff != 4'd0 && !space_ff) begin
                  space_in = 1'b1;
               end else begin
                  bad_in = 1'b1;
               end
            end
            LINE_MAXVAL: begin
               if (pos_ff >= 4'd3 ||
                   text_byte != ((pos_ff == 4'd0) ? CHAR_TWO : CHAR_FIVE))
                  bad_in = 1'b1;
            end
            default: begin
               if (is_digit)
                  sample_in = samp_next;
               else
                  bad_in = 1'b1;
            end
         endcase
         if (pos_ff != POS_MAX)
            pos_in = pos_ff + 4'd1;
      end else if (active) begin
         if (line_err != ERR_NONE) begin
            err_in = line_err;
         end else if (line_ff == LINE_MAXVAL) begin
            if (width_ff == '0 || height_ff == '0)
               done_in = 1'b1;
         end else if (line_ff == LINE_SAMPLE) begin
            if (pix_emit) begin
               sum_in  = '0;
               chan_in = CHAN_RED;
               if (col_wrap) begin
                  col_in = '0;
                  row_in = row_inc[DIM_W-1:0];
               end else begin
                  col_in = col_inc[DIM_W-1:0];
               end
               if (last_pix)
                  done_in = 1'b1;
            end else begin
               sum_in  = sum_next;
               chan_in = chan_ff + 2'd1;
            end
         end
         if (line_ff != LINE_SAMPLE)
            line_in = line_type'(line_ff + 3'd1);
         pos_in    = '0;
         bad_in    = 1'b0;
         space_in  = 1'b0;
         sample_in = '0;
      end
   end

   // result of a newline: error report or finished pixel
   assign row_wide = 32'(row_ff);
   assign col_wide = 32'(col_ff);

   always_comb begin
      result_valid = active && newline &&
                     (line_err != ERR_NONE || (line_ff == LINE_SAMPLE && pix_emit));
      if (line_err != ERR_NONE) begin
         result.pixel_word   = '0;
         result.pixel_row    = '0;
         result.pixel_column = '0;
         result.last_pixel   = 1'b0;
         result.error_code   = line_err;
      end else begin
         result.pixel_word   = sum_next;
         result.pixel_row    = row_wide[PIX_IDX_W-1:0];
         result.pixel_column = col_wide[PIX_IDX_W-1:0];
         result.last_pixel   = last_pix;
         result.error_code   = ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff   <= LINE_MAGIC;
         pos_ff    <= '0;
         bad_ff    <= 1'b0;
         space_ff  <= 1'b0;
         width_ff  <= '0;
         height_ff <= '0;
         sample_ff <= '0;
         chan_ff   <= CHAN_RED;
         sum_ff    <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         done_ff   <= 1'b0;
         err_ff    <= ERR_NONE;
      end else begin
         line_ff   <= line_in;
         pos_ff    <= pos_in;
         bad_ff    <= bad_in;
         space_ff  <= space_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         sample_ff <= sample_in;
         chan_ff   <= chan_in;
         sum_ff    <= sum_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         done_ff   <= done_in;
         err_ff    <= err_in;
      end
   end

endmodule

// ----- rtl/ppm_p3_text_pixel_decoder.sv -----
`timescale 1ns / 1ps
// ppm p3 text decoder top level: input byte register, line parser, result register
// depends on ppmp3_pkg, ppmp3_req_if, ppmp3_rsp_if and ppmp3_parser
//
// throughput: one request (one text byte) per cycle while results are taken;
// a result held by a stalled receiver also holds the next request
// path: a newline is held in the input byte register, then its result is loaded into the result register
// most requests give no result; a newline gives at most one pixel or error report
// reset: synchronous, clears the valid flags of both pipeline registers and all parser state

module ppm_p3_text_pixel_decoder #(
   parameter int unsigned MAX_DIM = ppmp3_pkg::MAX_DIM_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   ppmp3_req_if.sink   req_bus,
   ppmp3_rsp_if.source rsp_bus
);
   import ppmp3_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_data_ff, out_data_in;

   logic       req_take;
   logic       step;
   logic       res_valid;
   rsp_type    res_data;

   // the parser advances on a held byte when the result slot is free or being drained
   assign step     = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_take = req_bus.valid && req_bus.ready;

   // take a new byte when none is held or the held one moves on this cycle
   assign req_bus.ready = !in_valid_ff || step;

   ppmp3_parser #(
      .MAX_DIM (MAX_DIM)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .text_byte    (in_byte_ff),
      .result_valid (res_valid),
      .result       (res_data)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_bus.text_byte;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (step) begin
         // slot is free or emptied now; load whatever this byte produced
         out_valid_in = res_valid;
         if (res_valid)
            out_data_in = res_data;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      out_data_ff <= out_data_in;
   end

   // result channel
   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.pixel_word   = out_data_ff.pixel_word;
   assign rsp_bus.pixel_row    = out_data_ff.pixel_row;
   assign rsp_bus.pixel_column = out_data_ff.pixel_column;
   assign rsp_bus.last_pixel   = out_data_ff.last_pixel;
   assign rsp_bus.error_code   = out_data_ff.error_code;

endmodule
